// ===== src/fts_pkg.sv =====
// Shared types, constants and a helper function of the fragment transmit scheduler.
package fts_pkg;

    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int MAX_FRAGMENTS_DEF = 16;
    localparam int TICK_BITS_DEF     = 32;
    localparam int ID_BITS_DEF       = 32;

    localparam logic [7:0]  MIN_MTU_RESET  = 8'd32;
    localparam logic [7:0]  MAX_MTU_RESET  = 8'd255;
    localparam logic [31:0] DEADLINE_RESET = 32'd60000;

    localparam logic [1:0] REG_MIN_MTU  = 2'd0;
    localparam logic [1:0] REG_MAX_MTU  = 2'd1;
    localparam logic [1:0] REG_DEADLINE = 2'd2;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_PUMP    = 2'd1;
    localparam logic [1:0] OP_CANCEL  = 2'd2;

    localparam logic [1:0] POL_ALLOWED  = 2'd0;
    localparam logic [1:0] POL_DEFERRED = 2'd1;

    localparam logic [1:0] SEND_OK      = 2'd0;
    localparam logic [1:0] SEND_BLOCK   = 2'd1;
    localparam logic [1:0] SEND_DISCONN = 2'd2;
    localparam logic [1:0] SEND_FAIL    = 2'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MTU     = 3'd1;
    localparam logic [2:0] ERR_FULL    = 3'd2;
    localparam logic [2:0] ERR_DUP     = 3'd3;
    localparam logic [2:0] ERR_INVALID = 3'd4;

    localparam logic [9:0] JIT_INITIAL = 10'd250;
    localparam logic [9:0] JIT_RETRY   = 10'd100;
    localparam logic [9:0] JIT_GAP     = 10'd50;
    localparam logic [10:0] REPEAT_GAP = 11'd1000;
    localparam logic [10:0] RETRY_GAP  = 11'd100;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now;
        logic [31:0] msg_ident;
        logic [7:0]  mtu;
        logic [4:0]  fragment_count;
        logic [7:0]  random_byte;
        logic [7:0]  link_size;
        logic        link_closed;
        logic [1:0]  policy_status;
        logic [31:0] policy_not_before;
        logic [1:0]  tx_status;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  enqueue_error;
        logic        send_offer;
        logic [31:0] front_message_id;
        logic [3:0]  offer_fragment;
        logic        tx_logged;
        logic        event_valid;
        logic        event_kind;
        logic [3:0]  queued_after;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture input item
        logic scan;     // compare one queue entry against the new id
        logic exec;     // evaluate and commit the operation
    } fts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } fts_status_t;

    // byte * (top + 1) / 256
    function automatic logic [7:0] jitter(input logic [7:0] b, input logic [9:0] top);
        logic [17:0] p;
        begin
            p = 18'(b) * (18'(top) + 18'd1);
            jitter = p[15:8];
        end
    endfunction

endpackage

// ===== src/fragment_transmit_scheduler.sv =====
// Top level of the fragment transmit scheduler.
//
// A queue of outbound messages, each sent fragment by fragment in a first
// pass and then a repeat pass. The input channel (in_valid, in_stall, in_data)
// carries one operation per transfer: enqueue, pump tick or cancel all, with
// the link, policy and send answers for a pump. The output channel (out_valid,
// out_stall, out_data) returns exactly one result per input. Configuration is
// a plain write port (cfg_we, cfg_index, cfg_data) for the MTU bounds and the
// deadline; the user writes it while the block is idle; the block does not check.
//
// Each item passes the idle state, where it is accepted, then the scan state,
// which compares its id against each held message (ended early on a match),
// and then the exec state, where it is evaluated; the length of the scan over
// the queue sets how long an item takes. One item is worked on at a time.
// Reset empties the queue and loads the register defaults. When the
// receiver stalls, the result is held in the output register and the next
// item is captured and scanned, but it is not evaluated until that result's
// transfer completes; the input then stalls.
module fragment_transmit_scheduler #(
    parameter int QUEUE_DEPTH   = fts_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_FRAGMENTS = fts_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fts_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fts_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    fts_pkg::fts_cmd_t    cmd;
    fts_pkg::fts_status_t status;

    fts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
    );

    fts_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_FRAGMENTS(MAX_FRAGMENTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .status(status),
        .result(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );
endmodule

// ===== src/fts_ram.sv =====
// Generic single-port write, single-port registered-read RAM.
module fts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/fts_ctrl.sv =====
// Controller state machine of the fragment transmit scheduler.
module fts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output fts_pkg::fts_cmd_t   cmd,
    input  fts_pkg::fts_status_t status
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    // The output register takes a new result when it is empty or its transfer completes now.
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_valid;
        cmd.scan = (state_reg == S_SCAN);
        cmd.exec = (state_reg == S_EXEC) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (status.scan_done)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    // Wait until the previous result has left.
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    property p_exec_in_state;
        @(posedge clk) disable iff (!rst_n) cmd.exec |-> (state_reg == S_EXEC);
    endproperty
    a_exec_in_state: assert property (p_exec_in_state) else $error("exec outside exec state");

    property p_in_blocked;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_SCAN) |-> in_stall;
    endproperty
    a_in_blocked: assert property (p_in_blocked) else $error("input taken mid-item");

    property p_exec_once;
        @(posedge clk) disable iff (!rst_n)
            (cmd.exec && (!out_valid_reg || !out_stall)) |=> (out_valid && !cmd.exec);
    endproperty
    a_exec_once: assert property (p_exec_once) else $error("result not shown after exec");

    property p_scan_follows_load;
        @(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.scan;
    endproperty
    a_scan_follows_load: assert property (p_scan_follows_load) else $error("scan missing");
endmodule

// ===== src/fts_dp.sv =====
// Datapath of the fragment transmit scheduler: queue store, tallies and step logic.
module fts_dp #(
    parameter int QUEUE_DEPTH   = fts_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_FRAGMENTS = fts_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fts_pkg::in_item_t    in_item,
    input  fts_pkg::fts_cmd_t    cmd,
    output fts_pkg::fts_status_t status,
    output fts_pkg::out_item_t   result,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FA = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TA = QA + FA;

    fts_pkg::in_item_t  item_reg;
    fts_pkg::out_item_t result_reg;

    logic [7:0]  min_mtu_reg, max_mtu_reg;
    logic [31:0] deadline_reg;

    logic [QA-1:0] head_reg;
    logic [CW-1:0] held_reg;
    logic [CW-1:0] scan_reg;
    logic          dup_reg;

    // Per-slot queue entries held in registers (small, read at head and scan slot).
    logic [31:0] ids     [QUEUE_DEPTH];
    logic [7:0]  mtus    [QUEUE_DEPTH];
    logic [4:0]  totals  [QUEUE_DEPTH];
    logic [31:0] due     [QUEUE_DEPTH];
    logic [31:0] dline   [QUEUE_DEPTH];
    logic        rpt     [QUEUE_DEPTH];
    logic [FA:0] nxt     [QUEUE_DEPTH];

    // Offer tallies: a memory addressed by slot and fragment.
    logic          t_we;
    logic [TA-1:0] t_waddr, t_raddr;
    logic [1:0]    t_wdata, t_rdata;

    fts_ram #(.WIDTH(2), .DEPTH(1 << TA)) u_tally (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    // Each slot's tallies are cleared lazily: a per-slot touched mask marks
    // fragments already offered since the enqueue.
    logic [MAX_FRAGMENTS-1:0] touched [QUEUE_DEPTH];

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
        logic [33:0] s;
        begin
            s = {2'b0, a} + {1'b0, b};
            sat_add = (s > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
        end
    endfunction

    logic [QA-1:0] scan_slot;
    logic [QA-1:0] s;
    logic [QA-1:0] tail;
    logic [FA-1:0] f;
    logic [QA:0]   slot_sum;
    logic [QA:0]   tail_sum;

    // Both sums stay below twice the depth, so one conditional subtract wraps them.
    always_comb
    begin
        slot_sum = {1'b0, head_reg} + (QA+1)'(scan_reg);
        tail_sum = {1'b0, head_reg} + (QA+1)'(held_reg);
        scan_slot = (slot_sum >= (QA+1)'(QUEUE_DEPTH)) ?
                    QA'(slot_sum - (QA+1)'(QUEUE_DEPTH)) : QA'(slot_sum);
        tail      = (tail_sum >= (QA+1)'(QUEUE_DEPTH)) ?
                    QA'(tail_sum - (QA+1)'(QUEUE_DEPTH)) : QA'(tail_sum);
        s = head_reg;
        f = nxt[s][FA-1:0];
    end

    assign status.scan_done = (scan_reg >= held_reg) || dup_reg;
    assign t_raddr = {s, f};
    assign result  = result_reg;

    logic [1:0] tally;
    assign tally = touched[s][f] ? t_rdata : 2'd0;

    // Step evaluation.
    fts_pkg::out_item_t r;
    logic        do_push, do_pop, set_due, set_next, set_rpt, tally_w;
    logic [31:0] due_v;
    logic [FA:0] next_v;
    logic [1:0]  tally_v;
    logic        cancel;
    logic [FA:0] nxt_inc;

    always_comb
    begin
        r = '0;
        do_push = 1'b0; do_pop = 1'b0; set_due = 1'b0; set_next = 1'b0;
        set_rpt = 1'b0; tally_w = 1'b0; cancel = 1'b0;
        due_v = '0; next_v = '0; tally_v = '0;
        nxt_inc = nxt[s] + 1'b1;
        case (item_reg.opcode)
            fts_pkg::OP_ENQUEUE:
            begin
                if (item_reg.mtu < min_mtu_reg || item_reg.mtu > max_mtu_reg)
                    r.enqueue_error = fts_pkg::ERR_MTU;
                else if (held_reg >= CW'(QUEUE_DEPTH))
                    r.enqueue_error = fts_pkg::ERR_FULL;
                else if (dup_reg)
                    r.enqueue_error = fts_pkg::ERR_DUP;
                else if (item_reg.fragment_count == 5'd0 ||
                         32'(item_reg.fragment_count) > 32'(MAX_FRAGMENTS))
                    r.enqueue_error = fts_pkg::ERR_INVALID;
                else
                    do_push = 1'b1;
            end
            fts_pkg::OP_PUMP:
            begin
                if (held_reg != '0)
                begin
                    if (item_reg.now >= dline[s])
                    begin
                        do_pop = 1'b1;
                        if (!rpt[s])
                        begin
                            r.event_valid = 1'b1;
                            r.front_message_id = ids[s];
                        end
                    end
                    else if (item_reg.now < due[s])
                    begin
                    end
                    else if (item_reg.link_size != mtus[s] || item_reg.link_closed)
                    begin
                        do_pop = 1'b1;
                        if (!rpt[s])
                        begin
                            r.event_valid = 1'b1;
                            r.front_message_id = ids[s];
                        end
                    end
                    else if (rpt[s] && tally >= 2'd2)
                    begin
                        set_next = 1'b1; next_v = nxt_inc;
                        if (32'(nxt_inc) >= 32'(totals[s]))
                        begin
                            do_pop = 1'b1;
                        end
                        else
                        begin
                            set_due = 1'b1;
                            due_v = item_reg.now;
                        end
                    end
                    else if (item_reg.policy_status == fts_pkg::POL_DEFERRED)
                    begin
                        set_due = 1'b1;
                        due_v = (item_reg.policy_not_before > item_reg.now) ?
                                item_reg.policy_not_before :
                                sat_add(item_reg.now, 33'(fts_pkg::RETRY_GAP));
                    end
                    else if (item_reg.policy_status != fts_pkg::POL_ALLOWED)
                    begin
                        do_pop = 1'b1;
                        if (!rpt[s])
                        begin
                            r.event_valid = 1'b1;
                            r.front_message_id = ids[s];
                        end
                    end
                    else
                    begin
                        r.send_offer = 1'b1;
                        r.front_message_id = ids[s];
                        r.offer_fragment = 4'(f);
                        tally_v = (tally < 2'd3) ? tally + 2'd1 : tally;
                        tally_w = 1'b1;
                        if (item_reg.tx_status == fts_pkg::SEND_BLOCK ||
                            item_reg.tx_status == fts_pkg::SEND_DISCONN)
                        begin
                            if (tally_v >= 2'd2)
                            begin
                                if (!rpt[s])
                                begin
                                    do_pop = 1'b1; r.event_valid = 1'b1;
                                end
                                else
                                begin
                                    set_next = 1'b1; next_v = nxt_inc;
                                    if (32'(nxt_inc) >= 32'(totals[s]))
                                    begin
                                        do_pop = 1'b1;
                                    end
                                    else
                                    begin
                                        set_due = 1'b1;
                                        due_v = item_reg.now;
                                    end
                                end
                            end
                            else
                            begin
                                set_due = 1'b1;
                                due_v = sat_add(item_reg.now, 33'(fts_pkg::RETRY_GAP) +
                                        33'(fts_pkg::jitter(item_reg.random_byte,
                                                            fts_pkg::JIT_RETRY)));
                            end
                        end
                        else if (item_reg.tx_status == fts_pkg::SEND_FAIL)
                        begin
                            do_pop = 1'b1;
                            if (!rpt[s]) r.event_valid = 1'b1;
                        end
                        else
                        begin
                            r.tx_logged = 1'b1;
                            if (32'(nxt_inc) < 32'(totals[s]))
                            begin
                                set_next = 1'b1; next_v = nxt_inc;
                                set_due = 1'b1;
                                due_v = sat_add(item_reg.now, 33'(fts_pkg::jitter(
                                        item_reg.random_byte, fts_pkg::JIT_GAP)));
                            end
                            else if (!rpt[s])
                            begin
                                set_rpt = 1'b1; set_next = 1'b1; next_v = '0;
                                set_due = 1'b1;
                                due_v = sat_add(item_reg.now, 33'(fts_pkg::REPEAT_GAP) +
                                        33'(fts_pkg::jitter(item_reg.random_byte,
                                                            fts_pkg::JIT_INITIAL)));
                                r.event_valid = 1'b1; r.event_kind = 1'b1;
                            end
                            else
                            begin
                                do_pop = 1'b1;
                            end
                        end
                    end
                end
            end
            fts_pkg::OP_CANCEL:
            begin
                cancel = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    logic [CW-1:0] held_new;
    always_comb
    begin
        if (cancel) held_new = '0;
        else if (do_push) held_new = held_reg + 1'b1;
        else if (do_pop) held_new = held_reg - 1'b1;
        else held_new = held_reg;
    end

    // The full result, with the count of messages left after the step.
    fts_pkg::out_item_t r_full;
    always_comb
    begin
        r_full = r;
        r_full.queued_after = 4'(held_new);
    end

    assign t_we    = cmd.exec && tally_w;
    assign t_waddr = {s, f};
    assign t_wdata = tally_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mtu_reg  <= fts_pkg::MIN_MTU_RESET;
            max_mtu_reg  <= fts_pkg::MAX_MTU_RESET;
            deadline_reg <= fts_pkg::DEADLINE_RESET;
            head_reg     <= '0;
            held_reg     <= '0;
            scan_reg     <= '0;
            dup_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fts_pkg::REG_MIN_MTU:  min_mtu_reg  <= cfg_data[7:0];
                    fts_pkg::REG_MAX_MTU:  max_mtu_reg  <= cfg_data[7:0];
                    fts_pkg::REG_DEADLINE: deadline_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                scan_reg <= '0;
                dup_reg  <= 1'b0;
            end
            else if (cmd.scan && !status.scan_done)
            begin
                if (ids[scan_slot] == item_reg.msg_ident) dup_reg <= 1'b1;
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                held_reg <= held_new;
                if (cancel) head_reg <= '0;
                else if (do_pop)
                    head_reg <= (32'(head_reg) == QUEUE_DEPTH - 1) ? '0 : head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.exec)
        begin
            result_reg <= r_full;
            if (do_push)
            begin
                ids[tail]    <= item_reg.msg_ident;
                mtus[tail]   <= item_reg.mtu;
                totals[tail] <= item_reg.fragment_count;
                due[tail]    <= sat_add(item_reg.now, 33'(fts_pkg::jitter(
                                item_reg.random_byte, fts_pkg::JIT_INITIAL)));
                dline[tail]  <= sat_add(item_reg.now, 33'(deadline_reg));
                rpt[tail]    <= 1'b0;
                nxt[tail]    <= '0;
                touched[tail] <= '0;
            end
            if (set_due)  due[s] <= due_v;
            if (set_next) nxt[s] <= next_v;
            if (set_rpt)  rpt[s] <= 1'b1;
            if (tally_w)  touched[s][f] <= 1'b1;
        end
    end
endmodule

// ===== sim/fts_checker.sv =====
// Checker that predicts the scheduler's results from accepted inputs and compares them.
module fts_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  fts_pkg::in_item_t           in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  fts_pkg::out_item_t          out_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    output int                          fail_count,
    output int                          expected_left,
    output int                          results_seen,
    output int                          events_seen
);
    localparam int DEPTH = fts_pkg::QUEUE_DEPTH_DEF;
    localparam int FRAGS = fts_pkg::MAX_FRAGMENTS_DEF;

    logic [7:0]  mtu_floor;
    logic [7:0]  mtu_ceiling;
    logic [31:0] expiry_ticks;

    logic [31:0] slot_id [DEPTH];
    logic [7:0]  slot_mtu [DEPTH];
    logic [4:0]  slot_total [DEPTH];
    logic [31:0] slot_due [DEPTH];
    logic [31:0] slot_deadline [DEPTH];
    logic        slot_repeat [DEPTH];
    logic [4:0]  slot_next [DEPTH];
    logic [1:0]  slot_tally [DEPTH][FRAGS];
    int          front;
    int          held;

    fts_pkg::out_item_t pending_results [$];

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
    endfunction

    function automatic logic [31:0] jitter_of(input logic [7:0] b, input int top);
        jitter_of = (32'(b) * 32'(top + 1)) >> 8;
    endfunction

    task automatic drop_front(inout fts_pkg::out_item_t r);
        if (!slot_repeat[front])
        begin
            r.event_valid = 1'b1;
            r.event_kind = 1'b0;
            r.front_message_id = slot_id[front];
        end
        front = (front + 1) % DEPTH;
        held--;
    endtask

    task automatic advance_fragment(input int s, input logic [31:0] t);
        slot_next[s]++;
        if (slot_next[s] >= slot_total[s])
        begin
            front = (front + 1) % DEPTH;
            held--;
        end
        else
        begin
            slot_due[s] = t;
        end
    endtask

    function automatic logic [2:0] try_enqueue(input fts_pkg::in_item_t x);
        int s;
        begin
            if (x.mtu < mtu_floor || x.mtu > mtu_ceiling) return fts_pkg::ERR_MTU;
            if (held >= DEPTH) return fts_pkg::ERR_FULL;
            for (int i = 0; i < held; i++)
                if (slot_id[(front + i) % DEPTH] == x.msg_ident) return fts_pkg::ERR_DUP;
            if (x.fragment_count == 0 || x.fragment_count > FRAGS)
                return fts_pkg::ERR_INVALID;
            s = (front + held) % DEPTH;
            slot_id[s] = x.msg_ident;
            slot_mtu[s] = x.mtu;
            slot_total[s] = x.fragment_count;
            slot_due[s] = sat_add(x.now, jitter_of(x.random_byte, 250));
            slot_deadline[s] = sat_add(x.now, expiry_ticks);
            slot_repeat[s] = 1'b0;
            slot_next[s] = '0;
            for (int f = 0; f < FRAGS; f++) slot_tally[s][f] = '0;
            held++;
            return fts_pkg::ERR_NONE;
        end
    endfunction

    task automatic serve_front(input fts_pkg::in_item_t x, inout fts_pkg::out_item_t r);
        int s;
        int f;
        logic [31:0] t;
        t = x.now;
        if (held == 0) return;
        s = front;
        if (t >= slot_deadline[s])
        begin
            drop_front(r);
            return;
        end
        if (t < slot_due[s]) return;
        if (x.link_size != slot_mtu[s] || x.link_closed)
        begin
            drop_front(r);
            return;
        end
        f = slot_next[s] % FRAGS;
        if (slot_repeat[s] && slot_tally[s][f] >= 2)
        begin
            advance_fragment(s, t);
            return;
        end
        if (x.policy_status == fts_pkg::POL_DEFERRED)
        begin
            slot_due[s] = x.policy_not_before > t ? x.policy_not_before : sat_add(t, 100);
            return;
        end
        if (x.policy_status != fts_pkg::POL_ALLOWED)
        begin
            drop_front(r);
            return;
        end
        r.send_offer = 1'b1;
        r.front_message_id = slot_id[s];
        r.offer_fragment = 4'(f);
        if (slot_tally[s][f] < 3) slot_tally[s][f]++;
        if (x.tx_status == fts_pkg::SEND_BLOCK || x.tx_status == fts_pkg::SEND_DISCONN)
        begin
            if (slot_tally[s][f] >= 2)
            begin
                if (!slot_repeat[s]) drop_front(r);
                else advance_fragment(s, t);
                return;
            end
            slot_due[s] = sat_add(t, 100 + jitter_of(x.random_byte, 100));
            return;
        end
        if (x.tx_status == fts_pkg::SEND_FAIL)
        begin
            drop_front(r);
            return;
        end
        r.tx_logged = 1'b1;
        slot_next[s]++;
        if (slot_next[s] < slot_total[s])
        begin
            slot_due[s] = sat_add(t, jitter_of(x.random_byte, 50));
            return;
        end
        if (!slot_repeat[s])
        begin
            slot_repeat[s] = 1'b1;
            slot_next[s] = '0;
            slot_due[s] = sat_add(t, 1000 + jitter_of(x.random_byte, 250));
            r.event_valid = 1'b1;
            r.event_kind = 1'b1;
            return;
        end
        front = (front + 1) % DEPTH;
        held--;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fts_pkg::out_item_t r;
        if (!rst_n)
        begin
            mtu_floor <= fts_pkg::MIN_MTU_RESET;
            mtu_ceiling <= fts_pkg::MAX_MTU_RESET;
            expiry_ticks <= fts_pkg::DEADLINE_RESET;
            front = 0;
            held = 0;
            fail_count <= 0;
            results_seen <= 0;
            events_seen <= 0;
            expected_left <= 0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fts_pkg::REG_MIN_MTU:  mtu_floor <= cfg_data[7:0];
                    fts_pkg::REG_MAX_MTU:  mtu_ceiling <= cfg_data[7:0];
                    fts_pkg::REG_DEADLINE: expiry_ticks <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                r = '0;
                case (in_data.opcode)
                    fts_pkg::OP_ENQUEUE: r.enqueue_error = try_enqueue(in_data);
                    fts_pkg::OP_PUMP:    serve_front(in_data, r);
                    fts_pkg::OP_CANCEL:
                    begin
                        held = 0;
                        front = 0;
                    end
                    default: ;
                endcase
                r.queued_after = 4'(held);
                pending_results.insert(pending_results.size(), r);
            end
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (out_data.event_valid) events_seen <= events_seen + 1;
                if (pending_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result %p", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    r = pending_results.pop_front();
                    if (out_data !== r)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: result %0d expected %p got %p",
                                     results_seen, r, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            expected_left <= pending_results.size();
        end
    end
endmodule

// ===== sim/fragment_transmit_scheduler_tb.sv =====
// Top of the scheduler testbench: clock, reset, stimulus, configuration and verdict.
module fragment_transmit_scheduler_tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1830;
    localparam int IN_BITS = $bits(fts_pkg::in_item_t);

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    fts_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    fts_pkg::out_item_t out_data;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    int fail_count;
    int expected_left;
    int results_seen;
    int events_seen;
    int cycle_count;

    // Idle percentages per side; the stall process reads its own value every cycle.
    int send_idle_pct;
    int stall_pct;
    bit hold_off;

    // Model of the radio clock: it advances slowly so that due times and
    // deadlines are crossed during the random part.
    logic [31:0] radio_now;
    logic [31:0] id_pool [8];

    fragment_transmit_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fts_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .expected_left(expected_left),
        .results_seen(results_seen), .events_seen(events_seen)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random, or holds off solidly while hold_off is set.
    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a stuck handshake must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fragment_transmit_scheduler_tb NOT OK");
            $finish;
        end
    end

    // Offer one item and hold it until its transfer completes, with a random
    // gap in front of it according to the sender's idle percentage. Valid
    // stays high after the transfer; the next item or the drain replaces it.
    task automatic send_item(input fts_pkg::in_item_t x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= x;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Wait until every expected result has arrived plus the block's worst latency.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic fts_pkg::in_item_t random_fields();
        fts_pkg::in_item_t x;
        x = fts_pkg::in_item_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        x.opcode = 2'($urandom_range(2));
        return x;
    endfunction

    // A mostly well-formed pump: given link, mostly allowed policy, mostly accepted sends.
    function automatic fts_pkg::in_item_t link_pump(input logic [7:0] link_mtu);
        fts_pkg::in_item_t x;
        int r;
        x = random_fields();
        x.opcode = fts_pkg::OP_PUMP;
        x.now = radio_now;
        x.link_size = link_mtu;
        x.link_closed = ($urandom_range(99) < 2);
        r = $urandom_range(99);
        x.policy_status = r < 88 ? fts_pkg::POL_ALLOWED :
                          (r < 95 ? fts_pkg::POL_DEFERRED : 2'($urandom_range(3)));
        x.policy_not_before = radio_now + $urandom_range(300);
        r = $urandom_range(99);
        x.tx_status = r < 75 ? fts_pkg::SEND_OK :
                      (r < 93 ? 2'($urandom_range(1, 2)) : fts_pkg::SEND_FAIL);
        return x;
    endfunction

    function automatic fts_pkg::in_item_t enqueue_item(input logic [7:0] m,
                                                       input logic [4:0] n);
        fts_pkg::in_item_t x;
        x = random_fields();
        x.opcode = fts_pkg::OP_ENQUEUE;
        x.now = radio_now;
        x.msg_ident = id_pool[$urandom_range(7)];
        x.mtu = m;
        x.fragment_count = n;
        return x;
    endfunction

    // One random item: mostly enqueues and pumps on a shared link MTU,
    // with a little noise and the occasional cancel.
    task automatic random_item(input logic [7:0] link_mtu);
        fts_pkg::in_item_t x;
        int r;
        r = $urandom_range(999);
        radio_now = radio_now + $urandom_range(400);
        if (r < 230)
            x = enqueue_item($urandom_range(9) == 0 ? 8'($urandom) : link_mtu,
                             $urandom_range(19) == 0 ? 5'($urandom) : 5'($urandom_range(1, 4)));
        else if (r < 960)
            x = link_pump($urandom_range(29) == 0 ? 8'($urandom) : link_mtu);
        else if (r < 975)
        begin
            x = random_fields();
            x.opcode = fts_pkg::OP_CANCEL;
        end
        else if (r < 985)
        begin
            x = random_fields();
            x.opcode = 2'd3;
        end
        else
        begin
            x = random_fields();
        end
        send_item(x);
    endtask

    initial
    begin
        fts_pkg::in_item_t x;
        logic [7:0] link_mtu;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        radio_now = 32'd1000;
        for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
        id_pool[0] = 32'd0;
        id_pool[1] = 32'hFFFF_FFFF;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset register values: each enqueue error,
        // the edges of the fields, every opcode and the special cases.
        x = enqueue_item(8'd31, 5'd1);  send_item(x);        // MTU below floor
        x = enqueue_item(8'd64, 5'd0);  send_item(x);        // fragmentation failed
        x = enqueue_item(8'd64, 5'd17); send_item(x);        // too many fragments
        x = enqueue_item(8'd64, 5'd31); send_item(x);
        x = link_pump(8'd64); send_item(x);                  // pump on empty queue
        x = random_fields(); x.opcode = 2'd3; send_item(x);  // unknown opcode
        for (int i = 0; i < 8; i++)
        begin
            x = enqueue_item(8'd255, 5'd16);
            x.msg_ident = id_pool[i];
            x.random_byte = i[0] ? 8'hFF : 8'h00;
            send_item(x);
        end
        x = enqueue_item(8'd255, 5'd2); send_item(x);         // queue full
        x = link_pump(8'd255); x.now = 32'hFFFF_FFFF; send_item(x);  // expiry
        x = enqueue_item(8'd255, 5'd2); x.msg_ident = id_pool[3]; send_item(x); // duplicate
        x = link_pump(8'd255); x.now = 32'd1300; x.link_closed = 1'b1; send_item(x);
        x = link_pump(8'd255); x.now = 32'd1300; x.policy_status = fts_pkg::POL_DEFERRED;
        x.policy_not_before = 32'hFFFF_FFFF; send_item(x);
        x = link_pump(8'd254); x.now = 32'd1300; send_item(x);  // link mismatch
        x = random_fields(); x.opcode = fts_pkg::OP_CANCEL; send_item(x);
        drain();

        write_reg(fts_pkg::REG_MIN_MTU, 32'd0);
        write_reg(fts_pkg::REG_MAX_MTU, 32'd0);
        write_reg(fts_pkg::REG_DEADLINE, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'hDEAD_BEEF);
        // With both bounds at zero only a zero MTU is accepted.
        x = enqueue_item(8'd0, 5'd1); x.now = 32'hFFFF_FF00; send_item(x);
        x = enqueue_item(8'd1, 5'd1); send_item(x);
        drain();

        // Random phases, each with its own settings and idling pattern.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 85; stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  stall_pct = 85;
                end
                3:
                begin
                    send_idle_pct = 33; stall_pct = 33;
                end
                4:
                begin
                    send_idle_pct = 0;  stall_pct = 0;
                end
                default:
                begin
                    send_idle_pct = 20; stall_pct = 20;
                end
            endcase
            link_mtu = 8'($urandom_range(32, 255));
            write_reg(fts_pkg::REG_MIN_MTU,
                      phase == 4 ? 32'd255 : 32'($urandom_range(0, 32)));
            write_reg(fts_pkg::REG_MAX_MTU, 32'd255);
            write_reg(fts_pkg::REG_DEADLINE,
                      phase == 5 ? 32'd0 : 32'($urandom_range(300, 20000)));
            if (phase == 4) link_mtu = 8'd255;
            radio_now = phase == 5 ? 32'hFFFF_F000 : 32'($urandom);
            for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            begin
                // In the first phase the receiver stops for a long stretch
                // while items keep coming, so the block backs up its input.
                if (phase == 0 && n == 20)
                begin
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (200) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                random_item(link_mtu);
            end
            drain();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        $display("Checked %0d results, %0d of them with events, over six register settings.",
                 results_seen, events_seen);
        if (fail_count == 0)
            $display("fragment_transmit_scheduler_tb OK");
        else
            $display("fragment_transmit_scheduler_tb NOT OK");
        $finish;
    end
endmodule

// ===== fragment_transmit_scheduler.f =====
src/fts_pkg.sv
src/fts_ram.sv
src/fts_ctrl.sv
src/fts_dp.sv
src/fragment_transmit_scheduler.sv
sim/fts_checker.sv
sim/fragment_transmit_scheduler_tb.sv
